FILE: src/pse_pkg.sv
// pse_pkg: types, constants and the microcode table of the prime sieve engine
// used by every module of the block but pse_ram; depends on nothing

package pse_pkg;

  // flag store size and derived widths
  localparam int unsigned MAX_NUMBERS = 65536;
  localparam int unsigned MAX_TOP     = MAX_NUMBERS - 1;
  localparam int unsigned ADDR_W      = $clog2(MAX_NUMBERS);
  localparam int unsigned LIM_W       = 16;
  localparam int unsigned IDX_W       = LIM_W + 1;
  localparam int unsigned BASE_W      = LIM_W / 2 + 1;
  localparam int unsigned SQ_W        = 2 * BASE_W;
  localparam int unsigned STEP_W      = 4;
  localparam logic [LIM_W-1:0] LIMIT_RESET = '1;

  typedef logic [LIM_W-1:0]  lim_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [BASE_W-1:0] base_t;
  typedef logic [SQ_W-1:0]   sq_t;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic {
    ACT_SIEVE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SIEVE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef struct packed {
    action_t action;
    lim_t    number;
  } cmd_t;

  typedef struct packed {
    lim_t    prime_count;
    logic    is_prime;
    status_t status;
  } rsp_t;

  // microcode fields
  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,
    J_GOTO     = 3'd1,
    J_IF       = 3'd2,
    J_DISPATCH = 3'd3,
    J_WAIT_OUT = 3'd4
  } jmp_t;

  typedef enum logic [1:0] {
    C_IDX_LT_TOP   = 2'd0,
    C_SQ_GT_TOP    = 2'd1,
    C_FLAG_CLR     = 2'd2,
    C_MNEXT_LE_TOP = 2'd3
  } cond_t;

  typedef enum logic [2:0] {
    ADDR_IDX  = 3'd0,
    ADDR_ZERO = 3'd1,
    ADDR_ONE  = 3'd2,
    ADDR_BASE = 3'd3,
    ADDR_M    = 3'd4,
    ADDR_NUM  = 3'd5
  } addr_sel_t;

  typedef enum logic [1:0] {
    WE_OFF    = 2'd0,
    WE_ON     = 2'd1,
    WE_TOP_NZ = 2'd2
  } we_t;

  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_CLR  = 2'd1,
    IDX_INC  = 2'd2
  } idx_op_t;

  typedef enum logic [1:0] {
    BASE_HOLD = 2'd0,
    BASE_TWO  = 2'd1,
    BASE_INC  = 2'd2
  } base_op_t;

  typedef enum logic [1:0] {
    M_HOLD = 2'd0,
    M_SQ   = 2'd1,
    M_ADD  = 2'd2
  } m_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_CLR  = 2'd1,
    CNT_ACC  = 2'd2
  } cnt_op_t;

  typedef struct packed {
    jmp_t      jmp;
    cond_t     cond;
    step_t     target;
    addr_sel_t addr_sel;
    we_t       mem_we;
    logic      mem_wd;
    idx_op_t   idx_op;
    base_op_t  base_op;
    logic      sq_ld;
    m_op_t     m_op;
    cnt_op_t   cnt_op;
    logic      pend_set;
    logic      start;
    logic      total_ld;
    logic      qstat_ld;
    logic      flag_ld;
    logic      emit;
  } ctrl_t;

  typedef struct packed {
    logic idx_lt_top;
    logic sq_gt_top;
    logic flag_set;
    logic mnext_le_top;
  } flags_t;

  // program steps
  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_FILL  = 4'd1;
  localparam step_t S_CLR0  = 4'd2;
  localparam step_t S_CLR1  = 4'd3;
  localparam step_t S_SQ    = 4'd4;
  localparam step_t S_CHK   = 4'd5;
  localparam step_t S_TEST  = 4'd6;
  localparam step_t S_MARK  = 4'd7;
  localparam step_t S_NEXTB = 4'd8;
  localparam step_t S_CINIT = 4'd9;
  localparam step_t S_CNT   = 4'd10;
  localparam step_t S_CLAST = 4'd11;
  localparam step_t S_TOTAL = 4'd12;
  localparam step_t S_EMIT  = 4'd13;
  localparam step_t S_Q0    = 4'd14;
  localparam step_t S_Q1    = 4'd15;

  localparam ctrl_t UC_NOP = '{
    jmp: J_NEXT, cond: C_IDX_LT_TOP, target: S_IDLE, addr_sel: ADDR_IDX,
    mem_we: WE_OFF, mem_wd: 1'b0, idx_op: IDX_HOLD, base_op: BASE_HOLD,
    sq_ld: 1'b0, m_op: M_HOLD, cnt_op: CNT_HOLD, pend_set: 1'b0,
    start: 1'b0, total_ld: 1'b0, qstat_ld: 1'b0, flag_ld: 1'b0, emit: 1'b0
  };

  // effective limit, saturated to the top of the flag store
  function automatic lim_t eff_limit(input lim_t l);
    lim_t r;
    r = l;
    if (32'(l) > MAX_TOP) begin
      r = LIM_W'(MAX_TOP);
    end
    return r;
  endfunction

  // control store
  function automatic ctrl_t uc_word(input step_t s);
    ctrl_t w;
    w = UC_NOP;
    case (s)
      S_IDLE: begin
        w.start  = 1'b1;
        w.idx_op = IDX_CLR;
        w.jmp    = J_DISPATCH;
        w.target = S_FILL;
      end
      S_FILL: begin
        w.addr_sel = ADDR_IDX;
        w.mem_we   = WE_ON;
        w.mem_wd   = 1'b1;
        w.idx_op   = IDX_INC;
        w.jmp      = J_IF;
        w.cond     = C_IDX_LT_TOP;
        w.target   = S_FILL;
      end
      S_CLR0: begin
        w.addr_sel = ADDR_ZERO;
        w.mem_we   = WE_ON;
        w.base_op  = BASE_TWO;
      end
      S_CLR1: begin
        w.addr_sel = ADDR_ONE;
        w.mem_we   = WE_TOP_NZ;
      end
      S_SQ: begin
        w.sq_ld = 1'b1;
      end
      S_CHK: begin
        w.addr_sel = ADDR_BASE;
        w.jmp      = J_IF;
        w.cond     = C_SQ_GT_TOP;
        w.target   = S_CINIT;
      end
      S_TEST: begin
        w.m_op   = M_SQ;
        w.jmp    = J_IF;
        w.cond   = C_FLAG_CLR;
        w.target = S_NEXTB;
      end
      S_MARK: begin
        w.addr_sel = ADDR_M;
        w.mem_we   = WE_ON;
        w.m_op     = M_ADD;
        w.jmp      = J_IF;
        w.cond     = C_MNEXT_LE_TOP;
        w.target   = S_MARK;
      end
      S_NEXTB: begin
        w.base_op = BASE_INC;
        w.jmp     = J_GOTO;
        w.target  = S_SQ;
      end
      S_CINIT: begin
        w.idx_op = IDX_CLR;
        w.cnt_op = CNT_CLR;
      end
      S_CNT: begin
        w.addr_sel = ADDR_IDX;
        w.idx_op   = IDX_INC;
        w.cnt_op   = CNT_ACC;
        w.pend_set = 1'b1;
        w.jmp      = J_IF;
        w.cond     = C_IDX_LT_TOP;
        w.target   = S_CNT;
      end
      S_CLAST: begin
        w.cnt_op = CNT_ACC;
      end
      S_TOTAL: begin
        w.total_ld = 1'b1;
      end
      S_EMIT: begin
        w.emit   = 1'b1;
        w.jmp    = J_WAIT_OUT;
        w.target = S_IDLE;
      end
      S_Q0: begin
        w.addr_sel = ADDR_NUM;
        w.qstat_ld = 1'b1;
      end
      S_Q1: begin
        w.flag_ld = 1'b1;
        w.jmp     = J_GOTO;
        w.target  = S_EMIT;
      end
      default: begin
        w.jmp    = J_GOTO;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: src/pse_ram.sv
// pse_ram: generic single-port ram with registered read, no reset
// self-contained, no package needed

module pse_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: src/pse_sequencer.sv
// pse_sequencer: step counter, control store lookup and jump logic
// depends on pse_pkg

module pse_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  pse_pkg::action_t action,
  input  pse_pkg::flags_t flags,
  input  logic            out_free,
  output logic            idle,
  output pse_pkg::ctrl_t  ctrl
);

  import pse_pkg::*;

  step_t pc;
  step_t pc_next;
  ctrl_t word;
  logic  go;
  logic  cond_true;

  always_comb begin
    word = uc_word(pc);
    case (word.cond)
      C_IDX_LT_TOP:   cond_true = flags.idx_lt_top;
      C_SQ_GT_TOP:    cond_true = flags.sq_gt_top;
      C_FLAG_CLR:     cond_true = !flags.flag_set;
      C_MNEXT_LE_TOP: cond_true = flags.mnext_le_top;
      default:        cond_true = 1'b0;
    endcase
  end

  always_comb begin
    go      = 1'b1;
    pc_next = pc + 1'b1;
    case (word.jmp)
      J_NEXT: pc_next = pc + 1'b1;
      J_GOTO: pc_next = word.target;
      J_IF:   pc_next = cond_true ? word.target : pc + 1'b1;
      J_DISPATCH: begin
        go      = cmd_valid;
        pc_next = !cmd_valid ? pc : (action == ACT_QUERY) ? S_Q0 : word.target;
      end
      J_WAIT_OUT: begin
        go      = out_free;
        pc_next = out_free ? word.target : pc;
      end
      default: pc_next = S_IDLE;
    endcase
  end

  // a stalled step issues no datapath operation
  assign ctrl = go ? word : UC_NOP;
  assign idle = (pc == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

FILE: src/pse_datapath.sv
// pse_datapath: limit register, sieve working registers and the flag store
// depends on pse_pkg and pse_ram

module pse_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  pse_pkg::ctrl_t            ctrl,
  input  pse_pkg::cmd_t             cmd,
  input  logic                      limit_we,
  input  logic [pse_pkg::LIM_W-1:0] limit_wdata,
  output pse_pkg::flags_t           flags,
  output pse_pkg::rsp_t             res
);

  import pse_pkg::*;

  lim_t    limit;
  logic    sieve_done;
  lim_t    prime_total;
  lim_t    top;
  lim_t    cmd_num;
  idx_t    idx;
  base_t   base;
  sq_t     sq;
  idx_t    m;
  idx_t    count;
  logic    pend;
  logic    res_prime;
  status_t res_status;

  idx_t              addr_full;
  logic              wr_en;
  logic [0:0]        rdata;
  idx_t              mnext;

  always_comb begin
    case (ctrl.addr_sel)
      ADDR_IDX:  addr_full = idx;
      ADDR_ZERO: addr_full = '0;
      ADDR_ONE:  addr_full = IDX_W'(1);
      ADDR_BASE: addr_full = IDX_W'(base);
      ADDR_M:    addr_full = m;
      ADDR_NUM:  addr_full = IDX_W'(cmd_num);
      default:   addr_full = '0;
    endcase
  end

  assign wr_en = (ctrl.mem_we == WE_ON) || ((ctrl.mem_we == WE_TOP_NZ) && (top != '0));
  assign mnext = m + IDX_W'(base);

  pse_ram #(
    .WIDTH (1),
    .DEPTH (MAX_NUMBERS)
  ) u_flags (
    .clk   (clk),
    .we    (wr_en),
    .addr  (ADDR_W'(addr_full)),
    .wdata (ctrl.mem_wd),
    .rdata (rdata)
  );

  assign flags.idx_lt_top   = idx < IDX_W'(top);
  assign flags.sq_gt_top    = 32'(sq) > 32'(top);
  assign flags.flag_set     = rdata[0];
  assign flags.mnext_le_top = mnext <= IDX_W'(top);

  assign res.prime_count = prime_total;
  assign res.is_prime    = res_prime;
  assign res.status      = res_status;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      limit       <= LIMIT_RESET;
      sieve_done  <= 1'b0;
      prime_total <= '0;
      pend        <= 1'b0;
    end else begin
      pend <= ctrl.pend_set;
      if (ctrl.total_ld) begin
        prime_total <= (count > IDX_W'(LIMIT_RESET)) ? LIMIT_RESET : LIM_W'(count);
        sieve_done  <= 1'b1;
      end
      if (limit_we) begin
        limit      <= limit_wdata;
        sieve_done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= BASE_W'(2);
    end else begin
      case (ctrl.base_op)
        BASE_TWO: base <= BASE_W'(2);
        BASE_INC: base <= base + 1'b1;
        default:  base <= base;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      top     <= eff_limit(limit);
      cmd_num <= cmd.number;
    end
    case (ctrl.idx_op)
      IDX_CLR: idx <= '0;
      IDX_INC: idx <= idx + 1'b1;
      default: idx <= idx;
    endcase
    if (ctrl.sq_ld) begin
      sq <= base * base;
    end
    case (ctrl.m_op)
      M_SQ:    m <= IDX_W'(sq);
      M_ADD:   m <= mnext;
      default: m <= m;
    endcase
    case (ctrl.cnt_op)
      CNT_CLR: count <= '0;
      CNT_ACC: count <= count + IDX_W'(pend & rdata[0]);
      default: count <= count;
    endcase
    if (ctrl.total_ld) begin
      res_prime  <= 1'b0;
      res_status <= ST_OK;
    end
    if (ctrl.qstat_ld) begin
      if (!sieve_done) begin
        res_status <= ST_NO_SIEVE;
      end else if (cmd_num > top) begin
        res_status <= ST_RANGE;
      end else begin
        res_status <= ST_OK;
      end
    end
    if (ctrl.flag_ld) begin
      res_prime <= (res_status == ST_OK) && rdata[0];
    end
  end

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> addr_full <= IDX_W'(top))
    else $error("flag write beyond the effective limit");

  a_cfg_clears_done: assert property (@(posedge clk) disable iff (rst)
    limit_we |=> !sieve_done)
    else $error("limit write left the sieve marked done");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    ctrl.cnt_op == CNT_ACC |-> count <= idx)
    else $error("prime count ran ahead of the scan index");

endmodule

FILE: src/prime_sieve_engine.sv
// prime_sieve_engine: top level of the sieve of eratosthenes engine
// depends on pse_pkg, pse_sequencer, pse_datapath (and pse_ram below it)
//
//   channel | signals                      | beat contents
//   --------+------------------------------+--------------------------------
//   cmd     | cmd_valid, cmd_ready, cmd    | action (sieve/query), number
//   rsp     | rsp_valid, rsp_ready, rsp    | prime_count, is_prime, status
//   limit   | limit_we, limit_wdata        | largest number in the sieve
//
// a query beat takes the sequencer, accept to next accept, through dispatch,
// flag read, flag latch and result load
// a sieve beat, accept to next accept, fills the flag store up to L, the
// effective limit, runs a mark sweep for each prime base from 2 to isqrt(L)
// and then the count sweep; the single flag ram port carries one write or one read
// per cycle for the fill, mark and count sweeps
// rst is synchronous; it clears the limit to 65535, the done mark, the
// prime total and the step counter; flag contents stay unknown until a sieve
// cmd_ready is high whenever the sequencer waits at its idle step, also while
// a finished result still sits in the rsp register; a full rsp register
// holds the sequencer at its emit step until the beat is taken

module prime_sieve_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  pse_pkg::cmd_t             cmd,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output pse_pkg::rsp_t             rsp,
  input  logic                      limit_we,
  input  logic [pse_pkg::LIM_W-1:0] limit_wdata
);

  import pse_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;
  rsp_t   res;
  logic   out_free;
  logic   idle;

  // the output register can take a new beat when empty or draining
  assign out_free  = !rsp_valid || rsp_ready;
  assign cmd_ready = idle;

  // microcode sequencer: one control word per step
  pse_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .action    (cmd.action),
    .flags     (flags),
    .out_free  (out_free),
    .idle      (idle),
    .ctrl      (ctrl)
  );

  // registers, flag store and compare logic
  pse_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .cmd         (cmd),
    .limit_we    (limit_we),
    .limit_wdata (limit_wdata),
    .flags       (flags),
    .res         (res)
  );

  // result register, loaded by the emit step
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      rsp <= res;
    end
  end

  a_bad_status_not_prime: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> !rsp.is_prime)
    else $error("prime flag reported with an error status");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("sequencer stayed idle after taking a command beat");

  a_emit_into_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> out_free)
    else $error("result loaded over an unsent beat");

endmodule
